[hdl/rpn_pkg.sv]
`default_nettype none
package rpn_pkg;

  localparam int VALUE_W         = 32;
  localparam int FRAC_BITS       = 16;
  localparam int MAG_W           = VALUE_W + FRAC_BITS;
  localparam int STACK_DEPTH_DEF = 128;

  localparam logic [VALUE_W-1:0] MAX_POS = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] MIN_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_PUSH     = 4'd0,
    OP_ADD      = 4'd1,
    OP_SUB      = 4'd2,
    OP_MUL      = 4'd3,
    OP_DIV      = 4'd4,
    OP_REM      = 4'd5,
    OP_PEEK     = 4'd6,
    OP_DUP      = 4'd7,
    OP_SWAP     = 4'd8,
    OP_CLEAR    = 4'd9,
    OP_POP_SHOW = 4'd10
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_ZERO_DIV = 3'd3,
    ST_SAT      = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_GOT_B,
    S_DECIDE,
    S_GOT_A,
    S_EXEC,
    S_WAIT,
    S_SWAP1,
    S_SWAP2
  } state_t;

  typedef enum logic {
    RD_TOP,
    RD_SEC
  } rd_sel_t;

  typedef enum logic [1:0] {
    WA_SP,
    WA_TOP,
    WA_SEC
  } wr_sel_t;

  typedef enum logic [1:0] {
    WS_OPERAND,
    WS_B,
    WS_A,
    WS_RES
  } wr_src_t;

  typedef enum logic [1:0] {
    SP_HOLD,
    SP_INC,
    SP_DEC,
    SP_CLR
  } sp_op_t;

  typedef struct packed {
    logic    ld_in;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    ld_b;
    logic    ld_a;
    logic    wr_en;
    wr_sel_t wr_sel;
    wr_src_t wr_src;
    sp_op_t  sp_op;
    logic    alu_go;
    op_t     alu_op;
    logic    emit;
    status_t status;
    logic    show;
  } cmd_t;

  typedef struct packed {
    logic sp_zero;
    logic sp_lt2;
    logic sp_full;
    logic b_zero;
    logic alu_done;
    logic alu_sat;
  } stat_t;

  // magnitude and sign to value, clamped; returns {sat, value}
  function automatic logic [VALUE_W:0] fit_mag(input logic [MAG_W-1:0] m, input logic neg);
    logic [VALUE_W:0] r;
    if (!neg) begin
      if (m > MAG_W'(MAX_POS)) r = {1'b1, MAX_POS};
      else                     r = {1'b0, m[VALUE_W-1:0]};
    end else begin
      if (m > MAG_W'(MIN_NEG)) r = {1'b1, MIN_NEG};
      else                     r = {1'b0, VALUE_W'(-m[VALUE_W-1:0])};
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[hdl/rpn_ctrl.sv]
`default_nettype none
module rpn_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [3:0]    in_op,
  input  rpn_pkg::stat_t     stat,
  output logic               busy,
  output rpn_pkg::cmd_t      cmd
);

  rpn_pkg::state_t state_r, state_nxt;
  rpn_pkg::op_t    op_r, op_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpn_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

  assign busy = (state_r != rpn_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    unique case (state_r)
      rpn_pkg::S_IDLE: begin
        if (start) begin
          cmd.ld_in = 1'b1;
          op_nxt    = rpn_pkg::op_t'(in_op);
          state_nxt = rpn_pkg::S_DISPATCH;
        end
      end
      rpn_pkg::S_DISPATCH: begin
        state_nxt = rpn_pkg::S_IDLE;
        case (op_r)
          rpn_pkg::OP_PUSH: begin
            cmd.emit = 1'b1;
            if (stat.sp_full) begin
              cmd.status = rpn_pkg::ST_FULL;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = rpn_pkg::WA_SP;
              cmd.wr_src = rpn_pkg::WS_OPERAND;
              cmd.sp_op  = rpn_pkg::SP_INC;
            end
          end
          rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_SWAP: begin
            if (stat.sp_lt2) begin
              cmd.emit   = 1'b1;
              cmd.status = rpn_pkg::ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = rpn_pkg::RD_TOP;
              state_nxt  = rpn_pkg::S_GOT_B;
            end
          end
          rpn_pkg::OP_DIV, rpn_pkg::OP_REM, rpn_pkg::OP_PEEK, rpn_pkg::OP_DUP: begin
            if (stat.sp_zero) begin
              cmd.emit   = 1'b1;
              cmd.status = rpn_pkg::ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = rpn_pkg::RD_TOP;
              state_nxt  = rpn_pkg::S_GOT_B;
            end
          end
          rpn_pkg::OP_POP_SHOW: begin
            if (stat.sp_zero) begin
              cmd.emit = 1'b1;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = rpn_pkg::RD_TOP;
              state_nxt  = rpn_pkg::S_GOT_B;
            end
          end
          rpn_pkg::OP_CLEAR: begin
            cmd.sp_op = rpn_pkg::SP_CLR;
            cmd.emit  = 1'b1;
          end
          default: begin
            cmd.emit = 1'b1;
          end
        endcase
      end
      rpn_pkg::S_GOT_B: begin
        cmd.ld_b  = 1'b1;
        state_nxt = rpn_pkg::S_DECIDE;
      end
      rpn_pkg::S_DECIDE: begin
        state_nxt = rpn_pkg::S_IDLE;
        case (op_r)
          rpn_pkg::OP_DIV, rpn_pkg::OP_REM: begin
            if (stat.b_zero) begin
              // divisor is dropped even when it is the only entry
              cmd.sp_op  = rpn_pkg::SP_DEC;
              cmd.emit   = 1'b1;
              cmd.status = rpn_pkg::ST_ZERO_DIV;
            end else if (stat.sp_lt2) begin
              cmd.emit   = 1'b1;
              cmd.status = rpn_pkg::ST_EMPTY;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = rpn_pkg::RD_SEC;
              state_nxt  = rpn_pkg::S_GOT_A;
            end
          end
          rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_SWAP: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = rpn_pkg::RD_SEC;
            state_nxt  = rpn_pkg::S_GOT_A;
          end
          rpn_pkg::OP_PEEK: begin
            cmd.emit = 1'b1;
            cmd.show = 1'b1;
          end
          rpn_pkg::OP_DUP: begin
            cmd.emit = 1'b1;
            if (stat.sp_full) begin
              cmd.status = rpn_pkg::ST_FULL;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = rpn_pkg::WA_SP;
              cmd.wr_src = rpn_pkg::WS_B;
              cmd.sp_op  = rpn_pkg::SP_INC;
            end
          end
          rpn_pkg::OP_POP_SHOW: begin
            cmd.sp_op = rpn_pkg::SP_DEC;
            cmd.emit  = 1'b1;
            cmd.show  = 1'b1;
          end
          default: begin
            cmd.emit = 1'b1;
          end
        endcase
      end
      rpn_pkg::S_GOT_A: begin
        cmd.ld_a  = 1'b1;
        state_nxt = (op_r == rpn_pkg::OP_SWAP) ? rpn_pkg::S_SWAP1 : rpn_pkg::S_EXEC;
      end
      rpn_pkg::S_EXEC: begin
        cmd.alu_go = 1'b1;
        cmd.alu_op = op_r;
        state_nxt  = rpn_pkg::S_WAIT;
      end
      rpn_pkg::S_WAIT: begin
        if (stat.alu_done) begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = rpn_pkg::WA_SEC;
          cmd.wr_src = rpn_pkg::WS_RES;
          cmd.sp_op  = rpn_pkg::SP_DEC;
          cmd.emit   = 1'b1;
          cmd.status = stat.alu_sat ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK;
          state_nxt  = rpn_pkg::S_IDLE;
        end
      end
      rpn_pkg::S_SWAP1: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = rpn_pkg::WA_TOP;
        cmd.wr_src = rpn_pkg::WS_A;
        state_nxt  = rpn_pkg::S_SWAP2;
      end
      rpn_pkg::S_SWAP2: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = rpn_pkg::WA_SEC;
        cmd.wr_src = rpn_pkg::WS_B;
        cmd.emit   = 1'b1;
        state_nxt  = rpn_pkg::S_IDLE;
      end
      default: begin
        state_nxt = rpn_pkg::S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[hdl/rpn_dpath.sv]
`default_nettype none
module rpn_dpath #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic signed [rpn_pkg::VALUE_W-1:0] in_operand,
  input  rpn_pkg::cmd_t                       cmd,
  output rpn_pkg::stat_t                      stat,
  output logic                                out_valid,
  output logic signed [rpn_pkg::VALUE_W-1:0]  out_shown_value,
  output logic                                out_shown_valid,
  output logic [2:0]                          out_status,
  output logic [7:0]                          out_depth_after
);

  localparam int VW  = rpn_pkg::VALUE_W;
  localparam int MW  = rpn_pkg::MAG_W;
  localparam int FB  = rpn_pkg::FRAC_BITS;
  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int CW  = $clog2(MW);
  localparam logic [SPW-1:0] SP_FULL = SPW'(STACK_DEPTH);

  logic [VW-1:0] mem [STACK_DEPTH];
  logic [VW-1:0] rdata_r;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [VW-1:0] operand_r, b_r, a_r;
  logic [SPW-1:0] sp_m1, sp_m2;
  logic [AW-1:0]  raddr, waddr;
  logic [VW-1:0]  wdata;

  // ALU / divider
  rpn_pkg::op_t   alu_op_r;
  logic [2*VW-1:0] prod_r;
  logic           mul_pend_r, div_run_r, div_fin_r, done_r, sat_r;
  logic [VW-1:0]  res_r;
  logic [CW-1:0]  cnt_r;
  logic [MW-1:0]  dvd_r, quo_r;
  logic [VW-1:0]  rem_r;

  logic           neg_a, neg_b;
  logic [VW-1:0]  ma, mb, sum, diff;
  logic [VW:0]    rs, rs_sub;
  logic           ge;
  logic [VW:0]    fit_mul, fit_div;
  logic [VW-1:0]  rem_val;

  // output registers
  logic            out_valid_r, out_shown_valid_r;
  logic [VW-1:0]   out_shown_value_r;
  rpn_pkg::status_t out_status_r;
  logic [7:0]      out_depth_r;
  logic [SPW+7:0]  depth_ext;

  assign sp_m1 = sp_r - SPW'(1);
  assign sp_m2 = sp_r - SPW'(2);
  assign raddr = (cmd.rd_sel == rpn_pkg::RD_TOP) ? sp_m1[AW-1:0] : sp_m2[AW-1:0];

  always_comb begin
    case (cmd.wr_sel)
      rpn_pkg::WA_SP:  waddr = sp_r[AW-1:0];
      rpn_pkg::WA_TOP: waddr = sp_m1[AW-1:0];
      default:         waddr = sp_m2[AW-1:0];
    endcase
    case (cmd.wr_src)
      rpn_pkg::WS_OPERAND: wdata = operand_r;
      rpn_pkg::WS_B:       wdata = b_r;
      rpn_pkg::WS_A:       wdata = a_r;
      default:             wdata = res_r;
    endcase
    case (cmd.sp_op)
      rpn_pkg::SP_INC: sp_nxt = sp_r + SPW'(1);
      rpn_pkg::SP_DEC: sp_nxt = sp_m1;
      rpn_pkg::SP_CLR: sp_nxt = '0;
      default:         sp_nxt = sp_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) operand_r <= in_operand;
    if (cmd.ld_b)  b_r       <= rdata_r;
    if (cmd.ld_a)  a_r       <= rdata_r;
  end

  // operand a is the entry below the top, b the top
  assign neg_a = a_r[VW-1];
  assign neg_b = b_r[VW-1];
  assign ma    = neg_a ? VW'(-a_r) : a_r;
  assign mb    = neg_b ? VW'(-b_r) : b_r;
  assign sum   = a_r + b_r;
  assign diff  = a_r - b_r;

  // restoring divide, one quotient bit per cycle
  assign rs      = {rem_r, dvd_r[MW-1]};
  assign ge      = (rs >= {1'b0, mb});
  assign rs_sub  = rs - {1'b0, mb};

  assign fit_mul = rpn_pkg::fit_mag(prod_r[2*VW-1:FB], neg_a ^ neg_b);
  assign fit_div = rpn_pkg::fit_mag(quo_r, neg_a ^ neg_b);
  assign rem_val = neg_a ? VW'(-rem_r) : rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_pend_r <= 1'b0;
      div_run_r  <= 1'b0;
      div_fin_r  <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      done_r     <= 1'b0;
      mul_pend_r <= 1'b0;
      div_fin_r  <= 1'b0;
      if (cmd.alu_go) begin
        alu_op_r <= cmd.alu_op;
        case (cmd.alu_op)
          rpn_pkg::OP_ADD: begin
            done_r <= 1'b1;
            if (neg_a == neg_b && sum[VW-1] != neg_a) begin
              sat_r <= 1'b1;
              res_r <= neg_a ? rpn_pkg::MIN_NEG : rpn_pkg::MAX_POS;
            end else begin
              sat_r <= 1'b0;
              res_r <= sum;
            end
          end
          rpn_pkg::OP_SUB: begin
            done_r <= 1'b1;
            if (neg_a != neg_b && diff[VW-1] != neg_a) begin
              sat_r <= 1'b1;
              res_r <= neg_a ? rpn_pkg::MIN_NEG : rpn_pkg::MAX_POS;
            end else begin
              sat_r <= 1'b0;
              res_r <= diff;
            end
          end
          rpn_pkg::OP_MUL: begin
            prod_r     <= ma * mb;
            mul_pend_r <= 1'b1;
          end
          default: begin
            // div scales the dividend by the fraction bits, rem does not
            dvd_r     <= (cmd.alu_op == rpn_pkg::OP_DIV) ? {ma, {FB{1'b0}}} : MW'(ma);
            quo_r     <= '0;
            rem_r     <= '0;
            cnt_r     <= CW'(MW - 1);
            div_run_r <= 1'b1;
          end
        endcase
      end
      if (mul_pend_r) begin
        {sat_r, res_r} <= fit_mul;
        done_r         <= 1'b1;
      end
      if (div_run_r) begin
        rem_r <= ge ? rs_sub[VW-1:0] : rs[VW-1:0];
        quo_r <= {quo_r[MW-2:0], ge};
        dvd_r <= {dvd_r[MW-2:0], 1'b0};
        if (cnt_r == '0) begin
          div_run_r <= 1'b0;
          div_fin_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
      if (div_fin_r) begin
        done_r <= 1'b1;
        if (alu_op_r == rpn_pkg::OP_DIV) begin
          {sat_r, res_r} <= fit_div;
        end else begin
          sat_r <= 1'b0;
          res_r <= rem_val;
        end
      end
    end
  end

  assign stat.sp_zero  = (sp_r == '0);
  assign stat.sp_lt2   = (sp_r < SPW'(2));
  assign stat.sp_full  = (sp_r == SP_FULL);
  assign stat.b_zero   = (b_r == '0);
  assign stat.alu_done = done_r;
  assign stat.alu_sat  = sat_r;

  assign depth_ext = {8'd0, sp_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_shown_value_r <= cmd.show ? b_r : '0;
      out_shown_valid_r <= cmd.show;
      out_status_r      <= cmd.status;
      out_depth_r       <= depth_ext[7:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_shown_value = out_shown_value_r;
  assign out_shown_valid = out_shown_valid_r;
  assign out_status      = out_status_r;
  assign out_depth_after = out_depth_r;

endmodule
`default_nettype wire

[hdl/rpn_stack_evaluator.sv]
`default_nettype none
// RPN stack evaluator, one command item at a time; busy is high while an item is at work.
// Push, clear and empty-stack cases caught at dispatch end there; peek, dup, pop_show read
// the top; swap, add, sub read both entries, mul registers its product, div and rem use the
// shared 48-step restoring divider. Next item may start the cycle out_valid rises.
// Synchronous active-low reset empties the stack; store contents are not cleared.
// Results are one-cycle strobes on out_valid; the receiver cannot stall.
module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic [3:0]                         in_op,
  input  wire logic signed [rpn_pkg::VALUE_W-1:0] in_operand,
  output logic                                    out_valid,
  output logic signed [rpn_pkg::VALUE_W-1:0]      out_shown_value,
  output logic                                    out_shown_valid,
  output logic [2:0]                              out_status,
  output logic [7:0]                              out_depth_after
);

  rpn_pkg::cmd_t  cmd;
  rpn_pkg::stat_t stat;

  rpn_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  rpn_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_operand      (in_operand),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_shown_value (out_shown_value),
    .out_shown_valid (out_shown_valid),
    .out_status      (out_status),
    .out_depth_after (out_depth_after)
  );

  // a result always closes the item, so the block is free again
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while still busy");

  a_out_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without an item in work");

  a_show_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_shown_valid |-> out_status == rpn_pkg::ST_OK)
    else $error("shown value with error status");

endmodule
`default_nettype wire
